// ===== rtl/max_pool_2d_argmax_defines.svh =====
// Assertion macros shared by the max pooling block.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef MAX_POOL_2D_ARGMAX_DEFINES_SVH
`define MAX_POOL_2D_ARGMAX_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define MPA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define MPA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/mpa_pkg.sv =====
// Shared types and constants of the max pooling block.
// No dependencies; used by the top level, mpa_front and mpa_back.
package mpa_pkg;

   localparam int DEF_MAX_WINDOW = 8;
   localparam int DEF_MAX_LINE   = 512;
   localparam int SAMPLE_W       = 16;
   localparam int COORD_W        = 9;
   localparam int PLANE_W        = 16;
   localparam int SIZE_W         = 4;
   localparam int DIM_W          = 10;
   localparam int SLOT_W         = 4;
   localparam int CSR_INDEX_W    = 3;
   localparam int CSR_DATA_W     = 10;
   localparam int QUEUE_DEPTH    = 2;

   localparam logic [CSR_INDEX_W-1:0] REG_WINDOW_ROWS = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_WINDOW_COLS = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_STEP_ROWS   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_STEP_COLS   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_PLANE_ROWS  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_PLANE_COLS  = 3'd5;

   typedef struct packed {
      logic [SIZE_W-1:0] window_rows;
      logic [SIZE_W-1:0] window_cols;
   } cfg_type;

   typedef struct packed {
      logic [SLOT_W-1:0]  slot;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] out_row;
      logic [COORD_W-1:0] out_col;
      logic [PLANE_W-1:0] plane;
      logic               end_of_plane;
   } job_type;

endpackage

// ===== rtl/max_pool_2d_argmax.sv =====
// Top level of the 2-D max pooling block with argmax.
// Depends on mpa_pkg, mpa_front, mpa_queue, mpa_back and mpa_ram.
// A sample that completes no window is taken unless an earlier window is still queued or being
// processed. A sample that completes a window holds off further samples while the back end
// rereads every sample of the window through the single read port of the line store. The
// result sits in an output register, so the next sample is taken while it waits.
// Configuration writes are always ready and restart the scan of the current plane.
module max_pool_2d_argmax #(
   parameter int MAX_WINDOW = mpa_pkg::DEF_MAX_WINDOW,
   parameter int MAX_LINE   = mpa_pkg::DEF_MAX_LINE
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [mpa_pkg::SAMPLE_W-1:0] req_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [mpa_pkg::SAMPLE_W-1:0] rsp_max_value,
   output logic [mpa_pkg::COORD_W-1:0]         rsp_max_row,
   output logic [mpa_pkg::COORD_W-1:0]         rsp_max_col,
   output logic [mpa_pkg::COORD_W-1:0]         rsp_out_row,
   output logic [mpa_pkg::COORD_W-1:0]         rsp_out_col,
   output logic [mpa_pkg::PLANE_W-1:0]         rsp_plane_index,
   output logic                                rsp_end_of_plane,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mpa_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [mpa_pkg::CSR_DATA_W-1:0]      csr_data
);
   import mpa_pkg::*;

   localparam int AW = $clog2(MAX_WINDOW * MAX_LINE);

   logic                wr_en, rd_en, push, pop, job_ready, back_busy;
   logic [AW-1:0]       wr_addr, rd_addr;
   logic [SAMPLE_W-1:0] wr_data, rd_data;
   job_type             job_push, job_pop;
   cfg_type             cfg;

   assign csr_ready = 1'b1;

   mpa_front #(.MAX_WINDOW(MAX_WINDOW), .MAX_LINE(MAX_LINE)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_sample (req_sample),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .busy       (job_ready || back_busy),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .push       (push),
      .job        (job_push),
      .cfg        (cfg)
   );

   mpa_queue #(.WIDTH($bits(job_type)), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (job_push),
      .pop       (pop),
      .pop_data  (job_pop),
      .not_empty (job_ready)
   );

   mpa_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_WINDOW * MAX_LINE)) u_line_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   mpa_back #(.MAX_WINDOW(MAX_WINDOW), .MAX_LINE(MAX_LINE)) u_back (
      .clock            (clock),
      .reset            (reset),
      .job_ready        (job_ready),
      .job_in           (job_pop),
      .pop              (pop),
      .cfg              (cfg),
      .rd_en            (rd_en),
      .rd_addr          (rd_addr),
      .rd_data          (rd_data),
      .busy             (back_busy),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_max_value    (rsp_max_value),
      .rsp_max_row      (rsp_max_row),
      .rsp_max_col      (rsp_max_col),
      .rsp_out_row      (rsp_out_row),
      .rsp_out_col      (rsp_out_col),
      .rsp_plane_index  (rsp_plane_index),
      .rsp_end_of_plane (rsp_end_of_plane)
   );

endmodule

// ===== rtl/mpa_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module mpa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/mpa_queue.sv =====
// Short job queue between the front and the back of the pooling block.
// Depends on max_pool_2d_argmax_defines.svh for its assertions.
`include "max_pool_2d_argmax_defines.svh"
module mpa_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             not_empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] data_ff [DEPTH];
   logic [PW-1:0]    wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [CW-1:0]    count_ff, count_in;

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (push) begin
         wptr_in = (wptr_ff == PW'(DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (pop) begin
         rptr_in = (rptr_ff == PW'(DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
      if (push) begin
         data_ff[wptr_ff] <= push_data;
      end
   end

   assign pop_data  = data_ff[rptr_ff];
   assign not_empty = (count_ff != '0);

   `MPA_ASSERT_NOW(a_queue_no_overflow, clock, reset, push && !pop, count_ff < CW'(DEPTH), "job queue overflow")
   `MPA_ASSERT_NOW(a_queue_no_underflow, clock, reset, pop, count_ff != '0, "job queue underflow")

endmodule

// ===== rtl/mpa_front.sv =====
// Front of the pooling block: registers, scan counters, line store writes and window detection.
// Depends on mpa_pkg.
module mpa_front #(
   parameter int MAX_WINDOW = 8,
   parameter int MAX_LINE   = 512
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  logic signed [mpa_pkg::SAMPLE_W-1:0]       req_sample,
   input  logic                                      csr_valid,
   input  logic [mpa_pkg::CSR_INDEX_W-1:0]           csr_index,
   input  logic [mpa_pkg::CSR_DATA_W-1:0]            csr_data,
   input  logic                                      busy,
   output logic                                      wr_en,
   output logic [$clog2(MAX_WINDOW*MAX_LINE)-1:0]    wr_addr,
   output logic [mpa_pkg::SAMPLE_W-1:0]              wr_data,
   output logic                                      push,
   output mpa_pkg::job_type                          job,
   output mpa_pkg::cfg_type                          cfg
);
   import mpa_pkg::*;

   localparam int SW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int AW   = $clog2(MAX_WINDOW * MAX_LINE);
   localparam int WMAX = (MAX_WINDOW < 8) ? MAX_WINDOW : 8;
   localparam int LMAX = (MAX_LINE < 512) ? MAX_LINE : 512;

   logic [SIZE_W-1:0]  wr_raw_ff, wc_raw_ff, sr_raw_ff, sc_raw_ff;
   logic [DIM_W-1:0]   pr_raw_ff, pc_raw_ff;
   logic [SIZE_W-1:0]  wr, wc, sr, sc;
   logic [DIM_W-1:0]   pr, pc;
   logic [COORD_W-1:0] r_ff, r_in, c_ff, c_in;
   logic [SW-1:0]      slot_ff, slot_in;
   logic [2:0]         rmod_ff, rmod_in, cmod_ff, cmod_in;
   logic [COORD_W-1:0] oh_ff, oh_in, ow_ff, ow_in;
   logic [PLANE_W-1:0] plane_ff, plane_in;
   logic               fire, csr_hit, hit;
   logic [DIM_W-1:0]   r1, c1, r2, c2;

   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                    input logic [SIZE_W-1:0] hi);
      logic [SIZE_W-1:0] res;
      res = v;
      if (v == '0) begin
         res = SIZE_W'(1);
      end else if (v > hi) begin
         res = hi;
      end
      return res;
   endfunction

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] hi);
      logic [DIM_W-1:0] res;
      res = v;
      if (v == '0) begin
         res = DIM_W'(1);
      end else if (v > hi) begin
         res = hi;
      end
      return res;
   endfunction

   assign wr = clamp_size(wr_raw_ff, SIZE_W'(WMAX));
   assign wc = clamp_size(wc_raw_ff, SIZE_W'(WMAX));
   assign sr = clamp_size(sr_raw_ff, SIZE_W'(8));
   assign sc = clamp_size(sc_raw_ff, SIZE_W'(8));
   assign pr = clamp_dim(pr_raw_ff, DIM_W'(512));
   assign pc = clamp_dim(pc_raw_ff, DIM_W'(LMAX));

   assign req_stall = busy;
   assign fire      = req_valid && !busy;
   assign csr_hit   = csr_valid && (csr_index == REG_WINDOW_ROWS || csr_index == REG_WINDOW_COLS
                      || csr_index == REG_STEP_ROWS || csr_index == REG_STEP_COLS
                      || csr_index == REG_PLANE_ROWS || csr_index == REG_PLANE_COLS);

   assign r1 = {1'b0, r_ff} + DIM_W'(1);
   assign c1 = {1'b0, c_ff} + DIM_W'(1);
   assign r2 = r1 + DIM_W'(1);
   assign c2 = c1 + DIM_W'(1);

   assign hit = ({6'd0, wr} <= pr) && ({6'd0, wc} <= pc) && (r1 >= {6'd0, wr})
                && (c1 >= {6'd0, wc}) && (rmod_ff == '0) && (cmod_ff == '0);

   always_comb begin
      r_in     = r_ff;
      c_in     = c_ff;
      slot_in  = slot_ff;
      rmod_in  = rmod_ff;
      cmod_in  = cmod_ff;
      oh_in    = oh_ff;
      ow_in    = ow_ff;
      plane_in = plane_ff;
      if (fire) begin
         if (c1 >= pc) begin
            c_in    = '0;
            cmod_in = '0;
            ow_in   = '0;
            if (r1 >= pr) begin
               r_in     = '0;
               slot_in  = '0;
               rmod_in  = '0;
               oh_in    = '0;
               plane_in = plane_ff + 1'b1;
            end else begin
               r_in    = r_ff + 1'b1;
               slot_in = (slot_ff == SW'(MAX_WINDOW - 1)) ? '0 : slot_ff + 1'b1;
               if (r2 == {6'd0, wr}) begin
                  rmod_in = '0;
                  oh_in   = '0;
               end else if (r2 > {6'd0, wr}) begin
                  if ({1'b0, rmod_ff} + 4'd1 == sr) begin
                     rmod_in = '0;
                     oh_in   = oh_ff + 1'b1;
                  end else begin
                     rmod_in = rmod_ff + 1'b1;
                  end
               end
            end
         end else begin
            c_in = c_ff + 1'b1;
            if (c2 == {6'd0, wc}) begin
               cmod_in = '0;
               ow_in   = '0;
            end else if (c2 > {6'd0, wc}) begin
               if ({1'b0, cmod_ff} + 4'd1 == sc) begin
                  cmod_in = '0;
                  ow_in   = ow_ff + 1'b1;
               end else begin
                  cmod_in = cmod_ff + 1'b1;
               end
            end
         end
      end
      if (csr_hit) begin
         r_in    = '0;
         c_in    = '0;
         slot_in = '0;
         rmod_in = '0;
         cmod_in = '0;
         oh_in   = '0;
         ow_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_raw_ff <= SIZE_W'(2);
         wc_raw_ff <= SIZE_W'(2);
         sr_raw_ff <= SIZE_W'(2);
         sc_raw_ff <= SIZE_W'(2);
         pr_raw_ff <= DIM_W'(512);
         pc_raw_ff <= DIM_W'(512);
         r_ff      <= '0;
         c_ff      <= '0;
         slot_ff   <= '0;
         rmod_ff   <= '0;
         cmod_ff   <= '0;
         oh_ff     <= '0;
         ow_ff     <= '0;
         plane_ff  <= '0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               REG_WINDOW_ROWS: wr_raw_ff <= csr_data[SIZE_W-1:0];
               REG_WINDOW_COLS: wc_raw_ff <= csr_data[SIZE_W-1:0];
               REG_STEP_ROWS:   sr_raw_ff <= csr_data[SIZE_W-1:0];
               REG_STEP_COLS:   sc_raw_ff <= csr_data[SIZE_W-1:0];
               REG_PLANE_ROWS:  pr_raw_ff <= csr_data;
               REG_PLANE_COLS:  pc_raw_ff <= csr_data;
               default: ;
            endcase
         end
         r_ff     <= r_in;
         c_ff     <= c_in;
         slot_ff  <= slot_in;
         rmod_ff  <= rmod_in;
         cmod_ff  <= cmod_in;
         oh_ff    <= oh_in;
         ow_ff    <= ow_in;
         plane_ff <= plane_in;
      end
   end

   assign wr_en   = fire;
   assign wr_addr = AW'(slot_ff) * AW'(MAX_LINE) + AW'(c_ff);
   assign wr_data = req_sample;
   assign push    = fire && hit;

   assign job.slot         = SLOT_W'(slot_ff);
   assign job.row          = r_ff;
   assign job.col          = c_ff;
   assign job.out_row      = oh_ff;
   assign job.out_col      = ow_ff;
   assign job.plane        = plane_ff;
   assign job.end_of_plane = ({1'b0, r_ff} + {6'd0, sr} >= pr)
                             && ({1'b0, c_ff} + {6'd0, sc} >= pc);

   assign cfg.window_rows = wr;
   assign cfg.window_cols = wc;

endmodule

// ===== rtl/mpa_back.sv =====
// Back of the pooling block: rereads a completed window from the line store and finds the maximum.
// Depends on mpa_pkg and max_pool_2d_argmax_defines.svh.
`include "max_pool_2d_argmax_defines.svh"
module mpa_back #(
   parameter int MAX_WINDOW = 8,
   parameter int MAX_LINE   = 512
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   job_ready,
   input  mpa_pkg::job_type                       job_in,
   output logic                                   pop,
   input  mpa_pkg::cfg_type                       cfg,
   output logic                                   rd_en,
   output logic [$clog2(MAX_WINDOW*MAX_LINE)-1:0] rd_addr,
   input  logic [mpa_pkg::SAMPLE_W-1:0]           rd_data,
   output logic                                   busy,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [mpa_pkg::SAMPLE_W-1:0]    rsp_max_value,
   output logic [mpa_pkg::COORD_W-1:0]            rsp_max_row,
   output logic [mpa_pkg::COORD_W-1:0]            rsp_max_col,
   output logic [mpa_pkg::COORD_W-1:0]            rsp_out_row,
   output logic [mpa_pkg::COORD_W-1:0]            rsp_out_col,
   output logic [mpa_pkg::PLANE_W-1:0]            rsp_plane_index,
   output logic                                   rsp_end_of_plane
);
   import mpa_pkg::*;

   localparam int SW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int AW = $clog2(MAX_WINDOW * MAX_LINE);

   typedef enum logic [1:0] {S_IDLE, S_RUN, S_LAST, S_DONE} state_type;

   state_type                state_ff;
   job_type                  job_ff;
   logic [SIZE_W-1:0]        y_ff, x_ff;
   logic [SW-1:0]            slot_ff;
   logic [COORD_W-1:0]       row_ff, col_ff, left_ff, top_ff;
   logic                     rd_valid_ff;
   logic [COORD_W-1:0]       rd_row_ff, rd_col_ff;
   logic                     have_ff;
   logic signed [SAMPLE_W-1:0] best_ff;
   logic [COORD_W-1:0]       best_row_ff, best_col_ff;
   logic                     out_free, take, last_x, last_y, in_window;
   logic [4:0]               top_slot_wide;
   logic [SW-1:0]            top_slot;
   logic [COORD_W-1:0]       top, left;

   assign out_free = !rsp_valid || !rsp_stall;
   assign pop      = (state_ff == S_IDLE) && job_ready;
   assign busy     = (state_ff != S_IDLE);
   assign last_x   = (x_ff + 1'b1 == cfg.window_cols);
   assign last_y   = (y_ff + 1'b1 == cfg.window_rows);
   assign take     = rd_valid_ff && (!have_ff || $signed(rd_data) > best_ff);

   assign top  = job_in.row + 1'b1 - COORD_W'(cfg.window_rows);
   assign left = job_in.col + 1'b1 - COORD_W'(cfg.window_cols);

   always_comb begin
      top_slot_wide = 5'(job_in.slot) + 5'(MAX_WINDOW) - 5'(cfg.window_rows) + 5'd1;
      if (top_slot_wide >= 5'(MAX_WINDOW)) begin
         top_slot_wide = top_slot_wide - 5'(MAX_WINDOW);
      end
      top_slot = top_slot_wide[SW-1:0];
   end

   assign rd_en   = (state_ff == S_RUN);
   assign rd_addr = AW'(slot_ff) * AW'(MAX_LINE) + AW'(col_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         rd_valid_ff <= 1'b0;
         rsp_valid   <= 1'b0;
      end else begin
         rd_valid_ff <= (state_ff == S_RUN);
         if (state_ff == S_DONE && out_free) begin
            rsp_valid <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (job_ready) begin
                  state_ff <= S_RUN;
               end
            end
            S_RUN: begin
               if (last_x && last_y) begin
                  state_ff <= S_LAST;
               end
            end
            S_LAST: begin
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
      if (pop) begin
         job_ff  <= job_in;
         y_ff    <= '0;
         x_ff    <= '0;
         slot_ff <= top_slot;
         row_ff  <= top;
         col_ff  <= left;
         left_ff <= left;
         top_ff  <= top;
         have_ff <= 1'b0;
      end else if (state_ff == S_RUN) begin
         if (last_x) begin
            x_ff    <= '0;
            col_ff  <= left_ff;
            y_ff    <= y_ff + 1'b1;
            row_ff  <= row_ff + 1'b1;
            slot_ff <= (slot_ff == SW'(MAX_WINDOW - 1)) ? '0 : slot_ff + 1'b1;
         end else begin
            x_ff   <= x_ff + 1'b1;
            col_ff <= col_ff + 1'b1;
         end
      end
      rd_row_ff <= row_ff;
      rd_col_ff <= col_ff;
      if (take) begin
         have_ff     <= 1'b1;
         best_ff     <= $signed(rd_data);
         best_row_ff <= rd_row_ff;
         best_col_ff <= rd_col_ff;
      end
      if (state_ff == S_DONE && out_free) begin
         rsp_max_value    <= best_ff;
         rsp_max_row      <= best_row_ff;
         rsp_max_col      <= best_col_ff;
         rsp_out_row      <= job_ff.out_row;
         rsp_out_col      <= job_ff.out_col;
         rsp_plane_index  <= job_ff.plane;
         rsp_end_of_plane <= job_ff.end_of_plane;
      end
   end

   assign in_window = (best_row_ff >= top_ff) && (best_row_ff <= job_ff.row)
                      && (best_col_ff >= left_ff) && (best_col_ff <= job_ff.col);

   `MPA_ASSERT_NOW(a_back_pop_idle, clock, reset, pop, state_ff == S_IDLE, "job taken while busy")
   `MPA_ASSERT_NOW(a_back_max_in_window, clock, reset, state_ff == S_DONE, have_ff && in_window, "maximum outside its window")
   `MPA_ASSERT_NEXT(a_back_result_loaded, clock, reset, state_ff == S_DONE && out_free, rsp_valid, "result not presented")

endmodule
